@@ rtl/rwh_pkg.sv @@
// Shared widths, register codes, reset values and control types of the rolling window hash.
package rwh_pkg;

    localparam int HASH_W = 64;
    localparam int RANK_W = 8;
    localparam int BASE_W = 9;
    localparam int LEN_W  = 7;
    localparam int IDX_W  = 1;

    localparam int WINDOW_MAX_DEFAULT = 64;

    localparam logic [BASE_W-1:0] BASE_RESET       = 9'd4;
    localparam logic [LEN_W-1:0]  WINDOW_LEN_RESET = 7'd16;

    // register indexes on the config port
    localparam logic [IDX_W-1:0] REG_BASE       = 1'b0;
    localparam logic [IDX_W-1:0] REG_WINDOW_LEN = 1'b1;

    // per-step control from the sequencer to the hash datapath
    typedef struct packed {
        logic clear;      // restart or config write: hash 0, power 1
        logic mul_step;   // oldest-term subtract, power growth
        logic roll_step;  // times base plus new rank
        logic full;       // window already holds every slot
        logic grow_power; // prefix longer than one symbol: power *= base
    } roll_ctl_t;

endpackage

@@ rtl/rwh_store.sv @@
// Window symbol store: one write port, one read port, registered read data.
module rwh_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [rwh_pkg::RANK_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [rwh_pkg::RANK_W-1:0] rd_data
);
    import rwh_pkg::*;

    logic [RANK_W-1:0] mem [DEPTH];
    logic [RANK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/rwh_roll.sv @@
// Hash datapath: running hash, top power and the two multiply steps of one roll.
module rwh_roll (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rwh_pkg::roll_ctl_t         ctl,
    input  logic [rwh_pkg::BASE_W-1:0] base,
    input  logic [rwh_pkg::RANK_W-1:0] rank,
    input  logic [rwh_pkg::RANK_W-1:0] oldest,
    output logic [rwh_pkg::HASH_W-1:0] hash_next
);
    import rwh_pkg::*;

    logic [HASH_W-1:0] hash_reg;
    logic [HASH_W-1:0] power_reg;
    logic [HASH_W-1:0] diff_reg;
    logic [HASH_W-1:0] oldest_term;

    // base^(L-1) * oldest, modulo 2^64
    assign oldest_term = power_reg * HASH_W'(oldest);
    assign hash_next   = diff_reg * HASH_W'(base) + HASH_W'(rank);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg  <= '0;
            power_reg <= HASH_W'(1);
        end
        else if (ctl.clear)
        begin
            hash_reg  <= '0;
            power_reg <= HASH_W'(1);
        end
        else
        begin
            if (ctl.mul_step && ctl.grow_power)
            begin
                power_reg <= power_reg * HASH_W'(base);
            end
            if (ctl.roll_step)
            begin
                hash_reg <= hash_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_step)
        begin
            diff_reg <= ctl.full ? (hash_reg - oldest_term) : hash_reg;
        end
    end

endmodule

@@ rtl/rolling_window_hash.sv @@
// Top level of the rolling window hash: config, sequencer, window pointers, output register.
//
// Usage:
//   Slave stream s_*: one symbol rank per transaction in s_tdata, s_tuser set
//   when the symbol starts a new string (hash and window cleared first).
//   Master stream m_*: one result per input, the 64-bit hash of the prefix or
//   of the full window in m_tdata, m_tuser set once the window is full.
//   Config port: cfg_wr_en, cfg_index (0 = base, 1 = window_len), cfg_data.
//   Any write also clears the stream. Write only while the block is idle.
// Steps:
//   One item runs: accept plus store read, oldest-term multiply, times-base roll.
//   A new symbol is accepted only once the roll step is done. The dependent
//   64-bit products (by the 8-bit oldest rank, then by the 9-bit base) and the
//   registered store read set these steps; result valid is registered at the roll.
// Reset:
//   Hash 0, top power 1, window empty, base 4, window_len 16. The symbol store
//   is not cleared; an unwritten slot may be read, but its data is used only when full.
// Stalls:
//   The output register holds the result while m_tready is low; the next item
//   is still accepted and waits in its roll step until the register frees.
module rolling_window_hash #(
    parameter int WINDOW_MAX = rwh_pkg::WINDOW_MAX_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // slave stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] symbol_rank
    input  logic                       s_tuser,   // [0] restart
    // master stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [63:0]                m_tdata,   // [63:0] hash_value
    output logic                       m_tuser,   // [0] window_full
    // config write port
    input  logic                       cfg_wr_en,
    input  logic [rwh_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rwh_pkg::BASE_W-1:0] cfg_data
);
    import rwh_pkg::*;

    localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_ROLL = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [BASE_W-1:0] base_reg;
    logic [LEN_W-1:0]  window_len_reg;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [ADDR_W-1:0] oldest_reg, oldest_next;
    logic [RANK_W-1:0] rank_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [HASH_W-1:0] m_hash_reg;
    logic              m_full_reg;

    logic [CNT_W-1:0]  eff_len;
    logic [CNT_W-1:0]  oldest_inc;
    logic              accept;
    logic              restart;
    logic              full;
    logic              out_free;
    logic              roll_fire;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [RANK_W-1:0] oldest_rank;
    logic [HASH_W-1:0] hash_next;
    roll_ctl_t         ctl;

    // window length clamped to 1..WINDOW_MAX
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            eff_len = CNT_W'(1);
        end
        else if (32'(window_len_reg) > 32'(WINDOW_MAX))
        begin
            eff_len = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len = CNT_W'(window_len_reg);
        end
    end

    assign s_tready   = (state_reg == S_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign restart    = accept && s_tuser;
    assign full       = (fill_reg == eff_len);
    assign out_free   = !m_tvalid_reg || m_tready;
    assign roll_fire  = (state_reg == S_ROLL) && out_free;
    assign oldest_inc = CNT_W'(oldest_reg) + CNT_W'(1);

    // store write: the oldest slot once full, else the next free slot
    assign wr_en   = roll_fire;
    assign wr_addr = full ? oldest_reg : ADDR_W'(fill_reg);

    assign ctl.clear      = cfg_wr_en || restart;
    assign ctl.mul_step   = (state_reg == S_MUL);
    assign ctl.roll_step  = roll_fire;
    assign ctl.full       = full;
    assign ctl.grow_power = !full && (fill_reg != '0);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_ROLL;
            end
            S_ROLL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // window pointers
    always_comb
    begin
        fill_next   = fill_reg;
        oldest_next = oldest_reg;
        if (cfg_wr_en || restart)
        begin
            fill_next   = '0;
            oldest_next = '0;
        end
        else if (roll_fire)
        begin
            if (full)
            begin
                oldest_next = (oldest_inc >= eff_len) ? '0 : ADDR_W'(oldest_inc);
            end
            else
            begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (roll_fire)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            base_reg       <= BASE_RESET;
            window_len_reg <= WINDOW_LEN_RESET;
            fill_reg       <= '0;
            oldest_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            oldest_reg   <= oldest_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    REG_BASE:       base_reg       <= cfg_data;
                    REG_WINDOW_LEN: window_len_reg <= cfg_data[LEN_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rank_reg <= s_tdata;
        end
        if (roll_fire)
        begin
            m_hash_reg <= hash_next;
            m_full_reg <= full || ((fill_reg + CNT_W'(1)) == eff_len);
        end
    end

    // oldest symbol is read at acceptance and used in the multiply step
    rwh_store #(
        .DEPTH  (WINDOW_MAX),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (rank_reg),
        .rd_en   (accept),
        .rd_addr (oldest_reg),
        .rd_data (oldest_rank)
    );

    rwh_roll u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .base      (base_reg),
        .rank      (rank_reg),
        .oldest    (oldest_rank),
        .hash_next (hash_next)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_hash_reg;
    assign m_tuser  = m_full_reg;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for rolling_window_hash: stream stimulus, config phases, scoreboard.

typedef struct packed {
    logic [rwh_pkg::HASH_W-1:0] hash;
    logic                       full;
} hash_result_t;

class window_hash_board;
    // shadow of the config registers
    logic [rwh_pkg::BASE_W-1:0] base_r;
    logic [rwh_pkg::LEN_W-1:0]  len_r;
    // shadow of the hash state
    logic [rwh_pkg::HASH_W-1:0] hash_acc;
    logic [rwh_pkg::HASH_W-1:0] top_pow;
    logic [rwh_pkg::RANK_W-1:0] ranks [rwh_pkg::WINDOW_MAX_DEFAULT];
    int unsigned                oldest;
    int unsigned                filled;
    hash_result_t               pending_hashes [$];
    int unsigned                mismatches;
    int unsigned                results_seen;
    int unsigned                symbols_seen;
    int unsigned                full_seen;

    function new();
        base_r = rwh_pkg::BASE_RESET;
        len_r  = rwh_pkg::WINDOW_LEN_RESET;
        foreach (ranks[i]) ranks[i] = '0;
        mismatches   = 0;
        results_seen = 0;
        symbols_seen = 0;
        full_seen    = 0;
        clear_stream();
    endfunction

    function void clear_stream();
        hash_acc = '0;
        top_pow  = 64'd1;
        oldest   = 0;
        filled   = 0;
    endfunction

    function int unsigned pending();
        return pending_hashes.size();
    endfunction

    function void write_reg(logic [rwh_pkg::IDX_W-1:0] idx, logic [rwh_pkg::BASE_W-1:0] value);
        if (idx == rwh_pkg::REG_BASE)
            base_r = value;
        else
            len_r = value[rwh_pkg::LEN_W-1:0];
        clear_stream();
    endfunction

    // one accepted symbol -> one expected hash
    function void note_symbol(logic [rwh_pkg::RANK_W-1:0] rank, logic restart);
        int unsigned                span;
        int unsigned                slot;
        logic [rwh_pkg::HASH_W-1:0] b64;
        logic [rwh_pkg::HASH_W-1:0] r64;
        logic [rwh_pkg::HASH_W-1:0] o64;
        hash_result_t               res;
        span = 32'(len_r);
        if (span == 0) span = 1;
        if (span > rwh_pkg::WINDOW_MAX_DEFAULT) span = rwh_pkg::WINDOW_MAX_DEFAULT;
        b64 = {{(rwh_pkg::HASH_W-rwh_pkg::BASE_W){1'b0}}, base_r};
        r64 = {{(rwh_pkg::HASH_W-rwh_pkg::RANK_W){1'b0}}, rank};
        if (restart) clear_stream();
        if (filled > span) filled = span;
        if (oldest >= span) oldest = 0;
        if (filled < span) begin
            slot = oldest + filled;
            if (slot >= span) slot -= span;
            if (filled > 0) top_pow = top_pow * b64;
            hash_acc = hash_acc * b64 + r64;
            ranks[slot] = rank;
            filled++;
        end
        else begin
            o64 = {{(rwh_pkg::HASH_W-rwh_pkg::RANK_W){1'b0}}, ranks[oldest]};
            hash_acc = (hash_acc - top_pow * o64) * b64 + r64;
            ranks[oldest] = rank;
            oldest++;
            if (oldest >= span) oldest = 0;
        end
        res.hash = hash_acc;
        res.full = (filled == span);
        pending_hashes.push_back(res);
        symbols_seen++;
    endfunction

    function void check_hash(logic [rwh_pkg::HASH_W-1:0] hash, logic full);
        hash_result_t want;
        results_seen++;
        if (full === 1'b1) full_seen++;
        if (pending_hashes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: unexpected result hash=%h full=%b", hash, full);
            return;
        end
        want = pending_hashes.pop_front();
        if (hash !== want.hash || full !== want.full) begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: mismatch %0d: hash exp %h got %h, full exp %b got %b",
                         mismatches, want.hash, hash, want.full, full);
        end
    endfunction
endclass

module tb_top;
    import rwh_pkg::*;

    localparam int RANDOM_ITEMS = 1700;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [RANK_W-1:0]   s_tdata;   // [7:0] symbol_rank
    logic                s_tuser;   // [0] restart
    logic                m_tvalid;
    logic                m_tready;
    logic [HASH_W-1:0]   m_tdata;   // [63:0] hash_value
    logic                m_tuser;   // [0] window_full
    logic                cfg_wr_en;
    logic [IDX_W-1:0]    cfg_index;
    logic [BASE_W-1:0]   cfg_data;

    window_hash_board    board;
    bit                  no_idle;     // disables random gaps on both sides
    int unsigned         phase_count;
    int unsigned         restart_count;

    rolling_window_hash DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog. A normal run ends well before this limit.
    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    // Result side: check on the handshake, then pick the next ready value.
    // Both use the values sampled just before the edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_hash(m_tdata, m_tuser);
        m_tready <= no_idle || ($urandom_range(0, 99) >= 24);
    end

    // Drive one symbol; random gap first, then hold until the transaction completes.
    task automatic send_symbol(input logic [RANK_W-1:0] rank, input logic restart);
        while (!no_idle && $urandom_range(0, 99) < 24)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rank;
        s_tuser  <= restart;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        board.note_symbol(rank, restart);
        if (restart) restart_count++;
    endtask

    // Register writes only with the pipeline empty: wait until every expected result has
    // been checked before writing.
    task automatic program_regs(input bit set_base, input logic [BASE_W-1:0] base_val,
                                input bit set_len, input logic [BASE_W-1:0] len_val);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (set_base)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_BASE;
            cfg_data  <= base_val;
            @(posedge clk);
            board.write_reg(REG_BASE, base_val);
        end
        if (set_len)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= REG_WINDOW_LEN;
            cfg_data  <= len_val;
            @(posedge clk);
            board.write_reg(REG_WINDOW_LEN, len_val);
        end
        cfg_wr_en <= 1'b0;
        phase_count++;
    endtask

    initial
    begin
        int unsigned        sent;
        int unsigned        phase_len;
        int unsigned        k;
        int unsigned        sel;
        logic [BASE_W-1:0]  b_val;
        logic [BASE_W-1:0]  l_val;
        bit                 set_b;
        bit                 set_l;
        logic [RANK_W-1:0]  rank;
        logic               rflag;

        board         = new();
        no_idle       = 1'b0;
        phase_count   = 0;
        restart_count = 0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        m_tready      = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = REG_BASE;
        cfg_data      = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // Reset settings (base 4, len 16): extreme ranks, restart while filling.
        send_symbol(8'd255, 1'b0);
        send_symbol(8'd0,   1'b0);
        send_symbol(8'd255, 1'b0);
        send_symbol(8'd3,   1'b1);
        send_symbol(8'd1,   1'b0);

        // Base 256, short window of 4: fill, roll, restart while rolling.
        program_regs(1'b1, 9'd256, 1'b1, 9'd4);
        send_symbol(8'd255, 1'b0);
        send_symbol(8'd255, 1'b0);
        send_symbol(8'd0,   1'b0);
        send_symbol(8'd128, 1'b0);
        send_symbol(8'd255, 1'b0);
        send_symbol(8'd0,   1'b0);
        send_symbol(8'd77,  1'b0);
        send_symbol(8'd9,   1'b1);
        send_symbol(8'd200, 1'b0);
        send_symbol(8'd255, 1'b0);
        send_symbol(8'd255, 1'b0);
        send_symbol(8'd255, 1'b0);
        send_symbol(8'd1,   1'b0);

        // Ranks at or above the base are taken as they are.
        program_regs(1'b1, 9'd3, 1'b0, '0);
        send_symbol(8'd250, 1'b0);
        send_symbol(8'd5,   1'b0);
        send_symbol(8'd255, 1'b0);
        send_symbol(8'd2,   1'b0);
        send_symbol(8'd9,   1'b0);

        // ---- random part ----
        // Early phases pin the register extremes (including out-of-range codes and
        // write data with bits beyond the window_len field), later ones are random.
        sent = 0;
        k    = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_b = 1'b1;
            set_l = 1'b1;
            case (k)
                0:       begin b_val = 9'd1;   l_val = 9'd1;   end
                1:       begin b_val = 9'd256; l_val = 9'd64;  end
                2:       begin b_val = 9'd0;   l_val = 9'd0;   end
                3:       begin b_val = 9'd511; l_val = 9'd127; end
                4:       begin b_val = 9'd2;   l_val = 9'h182; end
                default:
                begin
                    sel   = $urandom_range(0, 3);
                    set_b = (sel != 1);
                    set_l = (sel != 2);
                    if ($urandom_range(0, 9) == 0)
                        b_val = BASE_W'($urandom_range(0, 511));
                    else
                        b_val = BASE_W'($urandom_range(1, 256));
                    if ($urandom_range(0, 9) == 0)
                        l_val = BASE_W'($urandom_range(0, 511));
                    else if ($urandom_range(0, 3) == 0)
                        l_val = BASE_W'($urandom_range(1, 64));
                    else
                        l_val = BASE_W'($urandom_range(1, 12));
                end
            endcase
            // one stretch with no gaps on either side
            no_idle = (k == 6 || k == 7);
            program_regs(set_b, b_val, set_l, l_val);

            phase_len = $urandom_range(60, 130);
            for (int unsigned i = 0; i < phase_len && sent < RANDOM_ITEMS; i++)
            begin
                // mostly ranks within the alphabet, some anywhere in the field
                if ($urandom_range(0, 99) < 85 && board.base_r >= 1 && board.base_r <= 256)
                    rank = RANK_W'($urandom_range(0, board.base_r - 1));
                else
                    rank = RANK_W'($urandom_range(0, 255));
                if (i == 0)
                    rflag = 1'($urandom_range(0, 1));
                else
                    rflag = ($urandom_range(0, 99) < 3);
                send_symbol(rank, rflag);
                sent++;
            end
            k++;
        end
        no_idle = 1'b0;

        // ---- drain ----
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);

        $display("tb: %0d symbols sent, %0d hashes checked (%0d with full window)",
                 board.symbols_seen, board.results_seen, board.full_seen);
        $display("tb: %0d config phases, %0d restarts, %0d mismatches",
                 phase_count, restart_count, board.mismatches);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
